FILE: design/hcbd_pkg.sv
// shared types, byte codes and helpers for the chunked body decoder
package hcbd_pkg;

  // decoder phase
  typedef enum logic [3:0] {
    PH_SIZE     = 4'd0,
    PH_SIZE_LF  = 4'd1,
    PH_DATA     = 4'd2,
    PH_DATA_CR  = 4'd3,
    PH_DATA_LF  = 4'd4,
    PH_FINAL_CR = 4'd5,
    PH_FINAL_LF = 4'd6,
    PH_DONE     = 4'd7,
    PH_ERROR    = 4'd8
  } phase_t;

  // error codes reported with each byte
  typedef enum logic [2:0] {
    ERR_NONE      = 3'd0,
    ERR_SIZE_CHAR = 3'd1,
    ERR_CHUNK_END = 3'd2,
    ERR_FINAL_END = 3'd3,
    ERR_OVERFLOW  = 3'd4
  } err_t;

  // delimiter bytes
  localparam logic [7:0] CHAR_CR   = 8'h0D;
  localparam logic [7:0] CHAR_LF   = 8'h0A;
  localparam int unsigned HEX_BITS = 4;

  // hex digit decode result
  typedef struct packed {
    logic       ok;
    logic [3:0] value;
  } hex_t;

  // decode one ascii hex digit, either case
  function automatic hex_t hex_decode(input logic [7:0] c);
    hex_t r;
    r.ok    = 1'b1;
    r.value = 4'd0;
    if (c >= 8'h30 && c <= 8'h39) begin
      r.value = 4'(c - 8'h30);
    end else if (c >= 8'h61 && c <= 8'h66) begin
      r.value = 4'(c - 8'h61 + 8'd10);
    end else if (c >= 8'h41 && c <= 8'h46) begin
      r.value = 4'(c - 8'h41 + 8'd10);
    end else begin
      r.ok = 1'b0;
    end
    return r;
  endfunction

endpackage

FILE: design/http_chunked_body_decoder_unit.sv
// chunked transfer body decoder, one body byte per transfer
//
//  channel  dir  signals                    contents
//  s        in   s_tvalid s_tready s_tdata  raw body byte
//  m        out  m_tvalid m_tready m_tdata  byte echo, error code
//                m_tuser m_tlast            payload / leftover flags, body end
//
// one byte per cycle while m is not stalled: the phase update and the size
// shift-add sit between the input port and the result register.
// a result shows in the cycle after its byte is taken.
// rst clears the phase, size, byte count and error latch.
// a stall on m holds the result register; s_tready follows m_tready while
// a result is waiting, so no byte is taken without room for its result.
module http_chunked_body_decoder_unit #(
  parameter int unsigned SIZE_WIDTH = 32
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,   // [7:0] in_byte
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [15:0] m_tdata,   // [7:0] out_byte, [10:8] error_code, rest zero
  output logic [1:0]  m_tuser,   // [0] data_valid, [1] leftover
  output logic        m_tlast    // done_res
);

  // decoder state
  hcbd_pkg::phase_t        phase, phase_next;
  logic [SIZE_WIDTH-1:0]   size_accum, size_accum_next;
  logic [1:0]              digit_count, digit_count_next;
  logic [SIZE_WIDTH-1:0]   bytes_left, bytes_left_next;
  hcbd_pkg::err_t          error_latch, error_latch_next;

  // result register
  logic [7:0]              out_byte;
  logic                    data_valid, leftover, done_res;
  logic                    dv_next, lo_next, dn_next;

  logic                    in_xfer;
  hcbd_pkg::hex_t          hex;
  logic [7:0]              c;

  assign s_tready = !m_tvalid || m_tready;
  assign in_xfer  = s_tvalid && s_tready;
  assign c        = s_tdata;
  assign hex      = hcbd_pkg::hex_decode(c);

  // next state and flags for the byte on the input port
  always_comb begin
    phase_next       = phase;
    size_accum_next  = size_accum;
    digit_count_next = digit_count;
    bytes_left_next  = bytes_left;
    error_latch_next = error_latch;
    dv_next          = 1'b0;
    lo_next          = 1'b0;
    dn_next          = 1'b0;
    unique case (phase)
      hcbd_pkg::PH_SIZE: begin
        if (c == hcbd_pkg::CHAR_CR) begin
          phase_next = hcbd_pkg::PH_SIZE_LF;
        end else if (!hex.ok) begin
          phase_next       = hcbd_pkg::PH_ERROR;
          error_latch_next = hcbd_pkg::ERR_SIZE_CHAR;
        end else if (size_accum[SIZE_WIDTH-1 -: hcbd_pkg::HEX_BITS] != '0) begin
          phase_next       = hcbd_pkg::PH_ERROR;
          error_latch_next = hcbd_pkg::ERR_OVERFLOW;
        end else begin
          size_accum_next = {size_accum[SIZE_WIDTH-hcbd_pkg::HEX_BITS-1:0], hex.value};
          if (digit_count != 2'd3) digit_count_next = digit_count + 2'd1;
        end
      end
      hcbd_pkg::PH_SIZE_LF: begin
        if (c != hcbd_pkg::CHAR_LF) begin
          phase_next       = hcbd_pkg::PH_ERROR;
          error_latch_next = hcbd_pkg::ERR_SIZE_CHAR;
        end else if (digit_count == 2'd1 && size_accum == '0) begin
          phase_next = hcbd_pkg::PH_FINAL_CR;
        end else begin
          bytes_left_next = size_accum;
          phase_next = (size_accum == '0) ? hcbd_pkg::PH_DATA_CR : hcbd_pkg::PH_DATA;
        end
        size_accum_next  = '0;
        digit_count_next = 2'd0;
      end
      hcbd_pkg::PH_DATA: begin
        dv_next = 1'b1;
        if (bytes_left != '0) bytes_left_next = bytes_left - 1'b1;
        if (bytes_left <= SIZE_WIDTH'(1)) phase_next = hcbd_pkg::PH_DATA_CR;
      end
      hcbd_pkg::PH_DATA_CR: begin
        if (c == hcbd_pkg::CHAR_CR) begin
          phase_next = hcbd_pkg::PH_DATA_LF;
        end else begin
          phase_next       = hcbd_pkg::PH_ERROR;
          error_latch_next = hcbd_pkg::ERR_CHUNK_END;
        end
      end
      hcbd_pkg::PH_DATA_LF: begin
        if (c == hcbd_pkg::CHAR_LF) begin
          phase_next = hcbd_pkg::PH_SIZE;
        end else begin
          phase_next       = hcbd_pkg::PH_ERROR;
          error_latch_next = hcbd_pkg::ERR_CHUNK_END;
        end
      end
      hcbd_pkg::PH_FINAL_CR: begin
        if (c == hcbd_pkg::CHAR_CR) begin
          phase_next = hcbd_pkg::PH_FINAL_LF;
        end else begin
          phase_next       = hcbd_pkg::PH_ERROR;
          error_latch_next = hcbd_pkg::ERR_FINAL_END;
        end
      end
      hcbd_pkg::PH_FINAL_LF: begin
        if (c == hcbd_pkg::CHAR_LF) begin
          dn_next    = 1'b1;
          phase_next = hcbd_pkg::PH_DONE;
        end else begin
          phase_next       = hcbd_pkg::PH_ERROR;
          error_latch_next = hcbd_pkg::ERR_FINAL_END;
        end
      end
      hcbd_pkg::PH_DONE: begin
        lo_next = 1'b1;
      end
      default: begin
        // error phase and unused codes hold everything
      end
    endcase
  end

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      phase       <= hcbd_pkg::PH_SIZE;
      size_accum  <= '0;
      digit_count <= 2'd0;
      bytes_left  <= '0;
      error_latch <= hcbd_pkg::ERR_NONE;
    end else if (in_xfer) begin
      phase       <= phase_next;
      size_accum  <= size_accum_next;
      digit_count <= digit_count_next;
      bytes_left  <= bytes_left_next;
      error_latch <= error_latch_next;
    end
  end

  // result valid
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (in_xfer) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  // result payload
  always_ff @(posedge clk) begin
    if (in_xfer) begin
      out_byte   <= c;
      data_valid <= dv_next;
      leftover   <= lo_next;
      done_res   <= dn_next;
    end
  end

  logic [2:0] err_out;

  // error code travels with the byte that raised it
  always_ff @(posedge clk) begin
    if (in_xfer) err_out <= error_latch_next;
  end

  assign m_tdata = {5'd0, err_out, out_byte};
  assign m_tuser = {leftover, data_valid};
  assign m_tlast = done_res;

  // payload and leftover never mark the same byte
  a_flags_excl: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> !(data_valid && leftover))
    else $error("data and leftover flags both set");

  // the error phase always carries a code
  a_err_code: assert property (@(posedge clk) disable iff (rst)
    phase == hcbd_pkg::PH_ERROR |-> error_latch != hcbd_pkg::ERR_NONE)
    else $error("error phase without code");

  // a completed body has no error
  a_done_ok: assert property (@(posedge clk) disable iff (rst)
    phase == hcbd_pkg::PH_DONE |-> error_latch == hcbd_pkg::ERR_NONE)
    else $error("done phase with error latched");

  // payload phase is entered only with bytes to go
  a_data_count: assert property (@(posedge clk) disable iff (rst)
    phase == hcbd_pkg::PH_DATA |-> bytes_left != '0)
    else $error("payload phase with zero count");

  // a byte taken after the body is flagged leftover
  a_leftover: assert property (@(posedge clk) disable iff (rst)
    in_xfer && phase == hcbd_pkg::PH_DONE |=> m_tvalid && leftover && !done_res)
    else $error("byte after body not flagged leftover");

endmodule
